FILE: rtl/vlsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlsu_pkg
// Shared opcodes, result kinds, controller/datapath interface types and
// the element-order table used by the fourth-store form.
// ----------------------------------------------------------------------------
package vlsu_pkg;

  localparam logic [4:0] OP_LBV = 5'd0;
  localparam logic [4:0] OP_SBV = 5'd1;
  localparam logic [4:0] OP_LSV = 5'd2;
  localparam logic [4:0] OP_SSV = 5'd3;
  localparam logic [4:0] OP_LLV = 5'd4;
  localparam logic [4:0] OP_SLV = 5'd5;
  localparam logic [4:0] OP_LDV = 5'd6;
  localparam logic [4:0] OP_SDV = 5'd7;
  localparam logic [4:0] OP_LPV = 5'd8;
  localparam logic [4:0] OP_SPV = 5'd9;
  localparam logic [4:0] OP_LUV = 5'd10;
  localparam logic [4:0] OP_SUV = 5'd11;
  localparam logic [4:0] OP_LHV = 5'd12;
  localparam logic [4:0] OP_SHV = 5'd13;
  localparam logic [4:0] OP_SFV = 5'd14;
  localparam logic [4:0] OP_SWV = 5'd15;
  localparam logic [4:0] OP_LQV = 5'd16;
  localparam logic [4:0] OP_SQV = 5'd17;
  localparam logic [4:0] OP_LRV = 5'd18;
  localparam logic [4:0] OP_SRV = 5'd19;
  localparam logic [4:0] OP_LTV = 5'd20;
  localparam logic [4:0] OP_STV = 5'd21;
  localparam logic [4:0] OP_HMEM = 5'd22;
  localparam logic [4:0] OP_HREG = 5'd23;

  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_MEM  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [1:0] CLS_NOP   = 2'd0;
  localparam logic [1:0] CLS_LOAD  = 2'd1;
  localparam logic [1:0] CLS_STORE = 2'd2;
  localparam logic [1:0] CLS_HOST  = 2'd3;

  // how a fetched byte or the host halfword lands in a register
  localparam logic [1:0] LM_BYTE = 2'd0;
  localparam logic [1:0] LM_EL8  = 2'd1;
  localparam logic [1:0] LM_EL7  = 2'd2;
  localparam logic [1:0] LM_HOST = 2'd3;

  typedef struct packed {
    logic       cap;
    logic       clr;
    logic       rd_issue;
    logic       host_wr;
    logic       emit_reg;
    logic       st_step;
    logic       emit_nop;
    logic       last;
    logic [3:0] step;
    logic [2:0] grp;
  } vlsu_cmd_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [4:0] count;
    logic       multi;
    logic       clr_done;
    logic       out_free;
  } vlsu_stat_t;

  // bit 3 valid, bits 2:0 table row
  function automatic logic [3:0] sfv_row(input logic [3:0] e);
    logic [3:0] r;
    case (e)
      4'd0, 4'd15: r = 4'b1000;
      4'd1:        r = 4'b1001;
      4'd4:        r = 4'b1010;
      4'd5:        r = 4'b1011;
      4'd8:        r = 4'b1100;
      4'd11:       r = 4'b1101;
      4'd12:       r = 4'b1110;
      default:     r = 4'b0000;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] sfv_elem(input logic [2:0] row, input logic [1:0] i);
    logic [11:0] t;
    case (row)
      3'd0:    t = {3'd0, 3'd1, 3'd2, 3'd3};
      3'd1:    t = {3'd6, 3'd7, 3'd4, 3'd5};
      3'd2:    t = {3'd1, 3'd2, 3'd3, 3'd0};
      3'd3:    t = {3'd7, 3'd4, 3'd5, 3'd6};
      3'd4:    t = {3'd4, 3'd5, 3'd6, 3'd7};
      3'd5:    t = {3'd3, 3'd0, 3'd1, 3'd2};
      3'd6:    t = {3'd5, 3'd6, 3'd7, 3'd4};
      default: t = '0;
    endcase
    return t[3*(3-int'(i)) +: 3];
  endfunction

endpackage

FILE: rtl/vector_load_store_unit.sv
`timescale 1ns / 1ps
// A store of n bytes gives its transfers one per cycle while the result register is free to take them.
// A load of n bytes reads one byte per cycle, then gives its register result after the last write-back.
// Transposed load: eight registers, each read and given in turn; an ignored or empty op gives one result.
// Throughput: one item at a time; a new item is taken only once the last one is through.
// Reset: in_ready stays low while the data memory is cleared one byte a cycle;
// the vector registers clear at once through per-register valid bits.
// ----------------------------------------------------------------------------
// vector_load_store_unit
// Vector load/store unit with 4 KB big-endian data memory and 32 x 128-bit
// vector registers.
// ----------------------------------------------------------------------------
module vector_load_store_unit #(
  parameter int MEMORY_BYTES = 4096,
  parameter int VECTOR_REG_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        in_op,
  input  logic [4:0]        in_vreg,
  input  logic [3:0]        in_element,
  input  logic signed [6:0] in_offset,
  input  logic [11:0]       in_base_value,
  input  logic [15:0]       in_host_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [4:0]        out_reg_index,
  output logic [63:0]       out_reg_high,
  output logic [63:0]       out_reg_low,
  output logic [11:0]       out_mem_address,
  output logic [7:0]        out_mem_byte,
  output logic              out_last
);

  import vlsu_pkg::*;

  vlsu_cmd_t  cmd;
  vlsu_stat_t stat;

  vlsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vlsu_datapath #(
    .MEMORY_BYTES     (MEMORY_BYTES),
    .VECTOR_REG_COUNT (VECTOR_REG_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_vreg         (in_vreg),
    .in_element      (in_element),
    .in_offset       (in_offset),
    .in_base_value   (in_base_value),
    .in_host_data    (in_host_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_reg_index   (out_reg_index),
    .out_reg_high    (out_reg_high),
    .out_reg_low     (out_reg_low),
    .out_mem_address (out_mem_address),
    .out_mem_byte    (out_mem_byte),
    .out_last        (out_last)
  );

endmodule

FILE: rtl/vlsu_dmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlsu_dmem
// Byte-wide data memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vlsu_dmem #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/vlsu_vrf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlsu_vrf
// Vector register file with byte enables; rows not yet written read as zero.
// ----------------------------------------------------------------------------
module vlsu_vrf #(
  parameter int COUNT = 32,
  localparam int RW = $clog2(COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [RW-1:0] waddr,
  input  logic [15:0]   bmask,
  input  logic [127:0]  wdata,
  input  logic [RW-1:0] raddr,
  output logic [127:0]  rdata
);

  logic [127:0]     rows [COUNT];
  logic [COUNT-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // byte 0 is the top byte; a first write to a row zeroes the untouched bytes
  always_ff @(posedge clk) begin
    if (we) begin
      for (int k = 0; k < 16; k++) begin
        if (bmask[k] || !valid_r[waddr]) begin
          rows[waddr][127-8*k -: 8] <= bmask[k] ? wdata[127-8*k -: 8] : 8'h00;
        end
      end
    end
  end

  assign rdata = valid_r[raddr] ? rows[raddr] : '0;

endmodule

FILE: rtl/vlsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlsu_datapath
// Item registers, address and step decode, memory, register file, load
// write-back stage and result register.
// ----------------------------------------------------------------------------
module vlsu_datapath #(
  parameter int MEMORY_BYTES = 4096,
  parameter int VECTOR_REG_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vlsu_pkg::vlsu_cmd_t  cmd,
  output vlsu_pkg::vlsu_stat_t stat,
  input  logic [4:0]        in_op,
  input  logic [4:0]        in_vreg,
  input  logic [3:0]        in_element,
  input  logic signed [6:0] in_offset,
  input  logic [11:0]       in_base_value,
  input  logic [15:0]       in_host_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [4:0]        out_reg_index,
  output logic [63:0]       out_reg_high,
  output logic [63:0]       out_reg_low,
  output logic [11:0]       out_mem_address,
  output logic [7:0]        out_mem_byte,
  output logic              out_last
);

  import vlsu_pkg::*;

  logic [4:0]  op_r, rt_r;
  logic [3:0]  el_r;
  logic [6:0]  off_r;
  logic [11:0] bv_r;
  logic [15:0] hd_r;

  logic [2:0]  sh;
  logic [11:0] off_ext, a, blk8, blk16, j12;
  logic [3:0]  a15, j4, idxp, idxs, e2, ix, mx;
  logic [2:0]  g3;
  logic [3:0]  sfv_rv;
  logic [2:0]  sfv_el;

  logic [1:0]  cls;
  logic [4:0]  cnt;
  logic [11:0] maddr;
  logic [4:0]  sreg;
  logic [3:0]  bsel;
  logic [1:0]  lmode;
  logic        sh7, zero, host;

  logic        p_valid_r;
  logic [4:0]  p_reg_r;
  logic [3:0]  p_b_r;
  logic [1:0]  p_mode_r;

  logic [11:0] clr_addr_r;
  logic [7:0]  mdata;
  logic [127:0] row;
  logic [15:0] win;
  logic [7:0]  st_val;

  logic        vw_we;
  logic [4:0]  vw_addr;
  logic [3:0]  vw_b;
  logic [1:0]  vw_mode;
  logic [7:0]  vw_hi, vw_lo;
  logic [15:0] vw_mask;
  logic [127:0] vw_data;

  logic        out_valid_r, out_last_r;
  logic [1:0]  out_kind_r;
  logic [4:0]  out_reg_index_r;
  logic [127:0] out_reg_r;
  logic [11:0] out_mem_address_r;
  logic [7:0]  out_mem_byte_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_op;
      rt_r  <= in_vreg;
      el_r  <= in_element;
      off_r <= in_offset;
      bv_r  <= in_base_value;
      hd_r  <= in_host_data;
    end
  end

  // access size is a power of two, so scaling is a shift
  always_comb begin
    if (op_r <= OP_SBV)      sh = 3'd0;
    else if (op_r <= OP_SSV) sh = 3'd1;
    else if (op_r <= OP_SLV) sh = 3'd2;
    else if (op_r <= OP_SUV) sh = 3'd3;
    else                     sh = 3'd4;
  end

  assign off_ext = {{5{off_r[6]}}, off_r};
  assign a       = bv_r + (off_ext << sh);
  assign a15     = a[3:0];
  assign blk8    = {a[11:3], 3'b000};
  assign blk16   = {a[11:4], 4'b0000};
  assign j4      = cmd.step;
  assign g3      = cmd.grp;
  assign j12     = {8'd0, j4};
  assign idxp    = {1'b0, a[2:0]} - el_r;
  assign e2      = {el_r[3:1], 1'b0};
  assign idxs    = {1'b0, a[2:0]} - e2;
  assign ix      = el_r + j4;
  assign mx      = (a15 > el_r) ? a15 : el_r;
  assign sfv_rv  = sfv_row(el_r);
  assign sfv_el  = sfv_elem(sfv_rv[2:0], j4[1:0]);

  always_comb begin
    cls   = CLS_NOP;
    cnt   = 5'd1;
    maddr = a + j12;
    sreg  = rt_r;
    bsel  = el_r + j4;
    lmode = LM_BYTE;
    sh7   = 1'b0;
    zero  = 1'b0;
    host  = 1'b0;
    case (op_r)
      OP_LBV: cls = CLS_LOAD;
      OP_LSV: begin
        cls = (el_r[0] || a[1:0] == 2'b11) ? CLS_NOP : CLS_LOAD;
        cnt = 5'd2;
      end
      OP_LLV: begin
        cls = (el_r[0] || a[0]) ? CLS_NOP : CLS_LOAD;
        cnt = 5'd4;
      end
      OP_LDV: begin
        cls = el_r[0] ? CLS_NOP : CLS_LOAD;
        cnt = (el_r > 4'd8) ? 5'd16 - {1'b0, el_r} : 5'd8;
      end
      OP_LQV: begin
        cls = (el_r[0] || a[0]) ? CLS_NOP : CLS_LOAD;
        cnt = 5'd16 - {1'b0, mx};
      end
      OP_LRV: begin
        cls   = (el_r != 4'd0 || a[0] || a15 == 4'd0) ? CLS_NOP : CLS_LOAD;
        cnt   = {1'b0, a15};
        maddr = blk16 + j12;
        bsel  = j4 - a15;
      end
      OP_LPV, OP_LUV: begin
        cls   = CLS_LOAD;
        cnt   = 5'd8;
        maddr = blk8 + {8'd0, j4 + idxp};
        bsel  = {j4[2:0], 1'b0};
        lmode = (op_r == OP_LPV) ? LM_EL8 : LM_EL7;
      end
      OP_LHV: begin
        cls   = (el_r != 4'd0 || a[3:1] != 3'd0) ? CLS_NOP : CLS_LOAD;
        cnt   = 5'd8;
        maddr = a + {7'd0, j4, 1'b0};
        bsel  = {j4[2:0], 1'b0};
        lmode = LM_EL7;
      end
      OP_LTV: begin
        cls   = (el_r[0] || rt_r[2:0] != 3'd0 || a15 != 4'd0) ? CLS_NOP : CLS_LOAD;
        cnt   = 5'd2;
        maddr = a + {8'd0, g3, j4[0]};
        sreg  = rt_r + {2'b00, g3};
        bsel  = {g3 - el_r[3:1], j4[0]};
      end
      OP_SBV: cls = CLS_STORE;
      OP_SSV: begin
        cls = CLS_STORE;
        cnt = 5'd2;
      end
      OP_SLV: begin
        cls = CLS_STORE;
        cnt = 5'd4;
      end
      OP_SDV: begin
        cls = CLS_STORE;
        cnt = 5'd8;
      end
      OP_SPV, OP_SUV: begin
        cls  = CLS_STORE;
        cnt  = 5'd8;
        bsel = {ix[2:0], 1'b0};
        sh7  = (!ix[3]) != (op_r == OP_SPV);
      end
      OP_SHV: begin
        cls   = CLS_STORE;
        cnt   = 5'd8;
        maddr = blk8 + {8'd0, {1'b0, a[2:0]} + {j4[2:0], 1'b0}};
        bsel  = el_r + {j4[2:0], 1'b0};
        sh7   = 1'b1;
      end
      OP_SFV: begin
        cls   = CLS_STORE;
        cnt   = 5'd4;
        maddr = blk8 + {8'd0, {1'b0, a[2:0]} + {j4[1:0], 2'b00}};
        bsel  = {sfv_el, 1'b0};
        sh7   = 1'b1;
        zero  = !sfv_rv[3];
      end
      OP_SWV: begin
        cls   = CLS_STORE;
        cnt   = 5'd16;
        maddr = blk8 + {8'd0, {1'b0, a[2:0]} + j4};
      end
      OP_SQV: begin
        cls = CLS_STORE;
        cnt = 5'd16 - {1'b0, a15};
      end
      OP_SRV: begin
        cls   = (a15 == 4'd0) ? CLS_NOP : CLS_STORE;
        cnt   = {1'b0, a15};
        maddr = blk16 + j12;
        bsel  = el_r + j4 - a15;
      end
      OP_STV: begin
        cls   = CLS_STORE;
        cnt   = 5'd16;
        maddr = blk8 + {8'd0, idxs + j4};
        sreg  = {rt_r[4:3], 3'b000} + {2'b00, j4[3:1]};
        bsel  = j4 - e2;
      end
      OP_HMEM: begin
        cls   = CLS_STORE;
        maddr = bv_r;
        host  = 1'b1;
      end
      OP_HREG: cls = CLS_HOST;
      default: cls = CLS_NOP;
    endcase
  end

  assign stat.cls      = cls;
  assign stat.count    = cnt;
  assign stat.multi    = (op_r == OP_LTV);
  assign stat.clr_done = &clr_addr_r;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + 12'd1;
    end
  end

  // load write-back stage, in the cycle after the memory read is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      p_reg_r  <= sreg;
      p_b_r    <= bsel;
      p_mode_r <= lmode;
    end
  end

  vlsu_dmem #(.DEPTH(MEMORY_BYTES)) u_dmem (
    .clk     (clk),
    .we      (cmd.clr || cmd.st_step),
    .waddr   (cmd.clr ? clr_addr_r : maddr),
    .wdata   (cmd.clr ? 8'h00 : st_val),
    .raddr   (maddr),
    .rdata_r (mdata)
  );

  assign vw_we   = p_valid_r || cmd.host_wr;
  assign vw_addr = cmd.host_wr ? rt_r : p_reg_r;
  assign vw_b    = cmd.host_wr ? {el_r[2:0], 1'b0} : p_b_r;
  assign vw_mode = cmd.host_wr ? LM_HOST : p_mode_r;

  always_comb begin
    case (vw_mode)
      LM_EL8: begin
        vw_hi = mdata;
        vw_lo = 8'h00;
      end
      LM_EL7: begin
        vw_hi = {1'b0, mdata[7:1]};
        vw_lo = {mdata[0], 7'd0};
      end
      LM_HOST: begin
        vw_hi = hd_r[15:8];
        vw_lo = hd_r[7:0];
      end
      default: begin
        vw_hi = mdata;
        vw_lo = 8'h00;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      vw_mask[k] = (4'(k) == vw_b) ||
                   ((vw_mode != LM_BYTE) && (4'(k) == {vw_b[3:1], 1'b1}));
      vw_data[127-8*k -: 8] = (4'(k) == vw_b) ? vw_hi : vw_lo;
    end
  end

  vlsu_vrf #(.COUNT(VECTOR_REG_COUNT)) u_vrf (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (vw_we),
    .waddr (vw_addr),
    .bmask (vw_mask),
    .wdata (vw_data),
    .raddr (sreg),
    .rdata (row)
  );

  // 16-bit window starting at byte bsel, wrapping inside the register
  assign win    = {row[{~bsel, 3'b111} -: 8], row[{~(bsel + 4'd1), 3'b111} -: 8]};
  assign st_val = host ? hd_r[7:0] : zero ? 8'h00 : sh7 ? win[14:7] : win[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_reg || cmd.st_step || cmd.emit_nop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_reg || cmd.st_step || cmd.emit_nop) begin
      out_last_r        <= cmd.last;
      out_kind_r        <= cmd.emit_reg ? KIND_REG : cmd.st_step ? KIND_MEM : KIND_NONE;
      out_reg_index_r   <= cmd.emit_reg ? sreg : 5'd0;
      out_reg_r         <= cmd.emit_reg ? row : '0;
      out_mem_address_r <= cmd.st_step ? maddr : 12'd0;
      out_mem_byte_r    <= cmd.st_step ? st_val : 8'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_last        = out_last_r;
  assign out_kind        = out_kind_r;
  assign out_reg_index   = out_reg_index_r;
  assign out_reg_high    = out_reg_r[127:64];
  assign out_reg_low     = out_reg_r[63:0];
  assign out_mem_address = out_mem_address_r;
  assign out_mem_byte    = out_mem_byte_r;

endmodule

FILE: rtl/vlsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlsu_ctrl
// Sequencer: memory clear after reset, then per item the read, write-back,
// host-write, store and result steps.
// ----------------------------------------------------------------------------
module vlsu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vlsu_pkg::vlsu_stat_t stat,
  output vlsu_pkg::vlsu_cmd_t  cmd
);

  import vlsu_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_LRD   = 4'd3;
  localparam logic [3:0] S_LWAIT = 4'd4;
  localparam logic [3:0] S_LEMIT = 4'd5;
  localparam logic [3:0] S_HWR   = 4'd6;
  localparam logic [3:0] S_ST    = 4'd7;
  localparam logic [3:0] S_NOP   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [2:0] grp_r, grp_nxt;
  logic       last_step, grp_last;

  assign last_step = ({1'b0, step_r} == stat.count - 5'd1);
  assign grp_last  = !stat.multi || (grp_r == 3'd7);
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.step  = step_r;
    cmd.grp   = grp_r;
    state_nxt = state_r;
    step_nxt  = step_r;
    grp_nxt   = grp_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        step_nxt = '0;
        grp_nxt  = '0;
        case (stat.cls)
          CLS_LOAD:  state_nxt = S_LRD;
          CLS_STORE: state_nxt = S_ST;
          CLS_HOST:  state_nxt = S_HWR;
          default:   state_nxt = S_NOP;
        endcase
      end
      S_LRD: begin
        cmd.rd_issue = 1'b1;
        if (last_step) state_nxt = S_LWAIT;
        else           step_nxt  = step_r + 4'd1;
      end
      S_LWAIT: state_nxt = S_LEMIT;
      S_LEMIT: begin
        if (stat.out_free) begin
          cmd.emit_reg = 1'b1;
          cmd.last     = grp_last;
          if (grp_last) begin
            state_nxt = S_IDLE;
          end else begin
            // transposed load: next register
            grp_nxt   = grp_r + 3'd1;
            step_nxt  = '0;
            state_nxt = S_LRD;
          end
        end
      end
      S_HWR: begin
        cmd.host_wr = 1'b1;
        state_nxt   = S_LEMIT;
      end
      S_ST: begin
        if (stat.out_free) begin
          cmd.st_step = 1'b1;
          cmd.last    = last_step;
          if (last_step) state_nxt = S_IDLE;
          else           step_nxt  = step_r + 4'd1;
        end
      end
      S_NOP: begin
        if (stat.out_free) begin
          cmd.emit_nop = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      step_r  <= '0;
      grp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      grp_r   <= grp_nxt;
    end
  end

endmodule

FILE: rtl/vlsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlsu_checker
// Port-level checks on the result channel and item sequencing.
// ----------------------------------------------------------------------------
module vlsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [4:0]  out_reg_index,
  input logic [63:0] out_reg_high,
  input logic [63:0] out_reg_low,
  input logic [11:0] out_mem_address,
  input logic [7:0]  out_mem_byte
);

  import vlsu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_REG |->
      out_reg_index == 5'd0 && out_reg_high == 64'd0 && out_reg_low == 64'd0)
    else $error("register fields set on a non-register result");

  a_mem_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_MEM |-> out_mem_address == 12'd0 && out_mem_byte == 8'd0)
    else $error("memory fields set on a non-memory result");

endmodule

bind vector_load_store_unit vlsu_checker u_vlsu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_reg_index   (out_reg_index),
  .out_reg_high    (out_reg_high),
  .out_reg_low     (out_reg_low),
  .out_mem_address (out_mem_address),
  .out_mem_byte    (out_mem_byte)
);
